// ----- design/brdf_pkg.sv -----
package brdf_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_A  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_B  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSES = 2'd2;

	// register reset values
	localparam logic [7:0] ADDR_A_RST  = 8'd7;
	localparam logic [7:0] ADDR_B_RST  = 8'd8;
	localparam logic [3:0] PRESSES_RST = 4'd2;

	// frame protocol codes
	localparam logic [7:0] FUNC_STATUS    = 8'h03;
	localparam logic [7:0] FUNC_ECHO      = 8'h10;
	localparam logic [7:0] STATUS_PRESSED = 8'h03;

	// byte positions inside a frame, address byte at zero
	localparam logic [2:0] POS_START       = 3'd0;
	localparam logic [2:0] POS_FUNC        = 3'd1;
	localparam logic [2:0] POS_STATUS      = 3'd3;
	localparam logic [2:0] POS_STATUS_LAST = 3'd6;
	localparam logic [2:0] POS_ECHO_LAST   = 3'd7;

	// lamp flag bits
	localparam logic [3:0] LAMP_A      = 4'b0001;
	localparam logic [3:0] LAMP_B      = 4'b0010;
	localparam logic [3:0] LAMP_SHARED = 4'b1100;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_FUNC = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	// one click report
	typedef struct packed {
		logic       button_id;
		logic [7:0] button_address;
		logic [3:0] light_flags;
	} click_t;

endpackage

// ----- design/brdf_parser.sv -----
module brdf_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             addr_a,
	input  logic [7:0]             addr_b,
	input  logic [3:0]             presses_needed,
	output logic                   click,
	output brdf_pkg::click_t       click_word
);
	import brdf_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	logic       is_status_q, is_status_d;
	logic       from_b_q, from_b_d;
	logic [7:0] status_q, status_d;
	logic [3:0] cnt_a_q, cnt_a_d;
	logic [3:0] cnt_b_q, cnt_b_d;
	logic [3:0] lamp_q, lamp_d;

	logic [2:0] pos_inc;
	logic [3:0] cnt_sel;
	logic [3:0] cnt_inc;
	logic       frame_done;
	logic       pressed;
	logic       reached;

	assign pos_inc    = pos_q + 3'd1;
	assign cnt_sel    = from_b_q ? cnt_b_q : cnt_a_q;
	assign cnt_inc    = cnt_sel + 4'd1;
	assign frame_done = (phase_q == PH_BODY) && is_status_q && (pos_inc == POS_STATUS_LAST);
	assign pressed    = (status_q == STATUS_PRESSED);
	assign reached    = (cnt_inc >= presses_needed);

	// next state
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		is_status_d = is_status_q;
		from_b_d    = from_b_q;
		status_d    = status_q;
		cnt_a_d     = cnt_a_q;
		cnt_b_d     = cnt_b_q;
		lamp_d      = lamp_q;
		if (step) begin
			case (phase_q)
				PH_FUNC: begin
					if (rx_byte == FUNC_STATUS || rx_byte == FUNC_ECHO) begin
						is_status_d = (rx_byte == FUNC_STATUS);
						phase_d     = PH_BODY;
						pos_d       = POS_FUNC;
					end else if (rx_byte == addr_a) begin
						from_b_d = 1'b0;
						phase_d  = PH_FUNC;
						pos_d    = POS_START;
					end else if (rx_byte == addr_b) begin
						from_b_d = 1'b1;
						phase_d  = PH_FUNC;
						pos_d    = POS_START;
					end else begin
						phase_d = PH_HUNT;
						pos_d   = POS_START;
					end
				end
				PH_BODY: begin
					pos_d = pos_inc;
					if (is_status_q) begin
						if (pos_inc == POS_STATUS) begin
							status_d = rx_byte;
						end
						if (frame_done) begin
							phase_d = PH_HUNT;
							pos_d   = POS_START;
							if (!pressed || reached) begin
								if (from_b_q) cnt_b_d = 4'd0;
								else          cnt_a_d = 4'd0;
							end else begin
								if (from_b_q) cnt_b_d = cnt_inc;
								else          cnt_a_d = cnt_inc;
							end
							if (pressed && reached) begin
								lamp_d = lamp_q | (from_b_q ? LAMP_B : LAMP_A) | LAMP_SHARED;
							end
						end
					end else if (pos_inc == POS_ECHO_LAST) begin
						phase_d = PH_HUNT;
						pos_d   = POS_START;
					end
				end
				default: begin
					// hunting, also the unused phase code
					if (rx_byte == addr_a) begin
						from_b_d = 1'b0;
						phase_d  = PH_FUNC;
						pos_d    = POS_START;
					end else if (rx_byte == addr_b) begin
						from_b_d = 1'b1;
						phase_d  = PH_FUNC;
						pos_d    = POS_START;
					end else begin
						phase_d = PH_HUNT;
						pos_d   = POS_START;
					end
				end
			endcase
		end
	end

	// click report
	always_comb begin
		click                     = step && frame_done && pressed && reached;
		click_word.button_id      = from_b_q;
		click_word.button_address = from_b_q ? addr_b : addr_a;
		click_word.light_flags    = lamp_q | (from_b_q ? LAMP_B : LAMP_A) | LAMP_SHARED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			pos_q       <= POS_START;
			is_status_q <= 1'b0;
			from_b_q    <= 1'b0;
			status_q    <= 8'd0;
			cnt_a_q     <= 4'd0;
			cnt_b_q     <= 4'd0;
			lamp_q      <= 4'd0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			is_status_q <= is_status_d;
			from_b_q    <= from_b_d;
			status_q    <= status_d;
			cnt_a_q     <= cnt_a_d;
			cnt_b_q     <= cnt_b_d;
			lamp_q      <= lamp_d;
		end
	end

endmodule

// ----- design/brdf_result_reg.sv -----
module brdf_result_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  brdf_pkg::click_t load_word,
	output logic             out_valid,
	input  logic             out_ready,
	output brdf_pkg::click_t out_word
);
	import brdf_pkg::*;

	logic   valid_q;
	click_t word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// ----- design/button_response_deframer_unit.sv -----
// button response deframer
//
// in channel (in_valid/in_ready/rx_byte): one received serial byte per word.
// the byte lands in an input register; the frame parser digests it from there
// and, on a click, loads the result register
// out channel (out_valid/out_ready/button_id/button_address/light_flags):
// one word per click, i.e. when a status frame completes with a pressed
// status and the button's press count reaches presses_needed
// a click word is loaded into the result register when the parser steps on
// its last frame byte. throughput: one byte per cycle, set by the single
// input register stage feeding the parser, as long as the receiver keeps up
// stall: while out_valid waits, at most one more byte is taken into the
// input register; further bytes wait until the result word is taken
// config: write port cfg_we/cfg_index/cfg_data, for the user to write only
// while idle (not enforced); index 0/1 button A/B address, 2 presses needed
// reset: parser hunts for an address, press counts and lamp flags clear,
// registers take their default values, both channels empty
module button_response_deframer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [brdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           button_id,
	output logic [7:0]                     button_address,
	output logic [3:0]                     light_flags
);
	import brdf_pkg::*;

	// configuration registers
	logic [7:0] addr_a_q;
	logic [7:0] addr_b_q;
	logic [3:0] presses_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	logic   advance;
	logic   click;
	click_t click_word;
	click_t out_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_a_q  <= ADDR_A_RST;
			addr_b_q  <= ADDR_B_RST;
			presses_q <= PRESSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDR_A:  addr_a_q  <= cfg_data;
				REG_ADDR_B:  addr_b_q  <= cfg_data;
				REG_PRESSES: presses_q <= cfg_data[3:0];
				default: ; // no register there
			endcase
		end
	end

	// parser moves when a byte is held and the result register has room
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	brdf_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.rx_byte        (byte_s1),
		.addr_a         (addr_a_q),
		.addr_b         (addr_b_q),
		.presses_needed (presses_q),
		.click          (click),
		.click_word     (click_word)
	);

	brdf_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (click),
		.load_word (click_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	assign button_id      = out_word.button_id;
	assign button_address = out_word.button_address;
	assign light_flags    = out_word.light_flags;

endmodule

// ----- sim/button_response_deframer_unit_tb.sv -----
module button_response_deframer_unit_tb;
	import brdf_pkg::*;

	// cycles with no word moving on either side before the run is declared hung
	localparam int WATCHDOG_LIMIT = 2000;
	// cycles to let the input register and parser settle once no click is due
	localparam int SETTLE_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ADDR_A;
	logic [7:0] cfg_data = 8'h00;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic button_id;
	logic [7:0] button_address;
	logic [3:0] light_flags;

	button_response_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.button_id(button_id),
		.button_address(button_address),
		.light_flags(light_flags)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the register file, updated when the port writes it
	logic [7:0] addr_a_shadow = ADDR_A_RST;
	logic [7:0] addr_b_shadow = ADDR_B_RST;
	logic [3:0] presses_shadow = PRESSES_RST;

	// shadow copy of the parser and press counters
	phase_t frame_phase = PH_HUNT;
	logic [2:0] frame_pos = POS_START;
	logic frame_status = 1'b0;
	logic frame_b = 1'b0;
	logic [7:0] frame_status_byte = 8'h00;
	logic [3:0] presses_a = 4'd0;
	logic [3:0] presses_b = 4'd0;
	logic [3:0] lamps = 4'd0;

	// click words the block still owes, oldest first
	click_t clicks_due[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;

	// count of accepted input words, used to size the random phases
	int accepted_bytes = 0;
	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			accepted_bytes <= accepted_bytes + 1;

	// a byte that is not a frame body byte: either opens a frame or keeps hunting
	function automatic void seek_address(input logic [7:0] b);
		if (b == addr_a_shadow) begin
			frame_b = 1'b0;
			frame_phase = PH_FUNC;
		end else if (b == addr_b_shadow) begin
			frame_b = 1'b1;
			frame_phase = PH_FUNC;
		end else begin
			frame_phase = PH_HUNT;
		end
		frame_pos = POS_START;
	endfunction

	// advance the frame parser by one byte; queue a click word when one is due
	function automatic void parse_byte(input logic [7:0] b);
		logic [3:0] cnt;
		click_t word;
		case (frame_phase)
			PH_FUNC: begin
				if (b == FUNC_STATUS || b == FUNC_ECHO) begin
					frame_status = (b == FUNC_STATUS);
					frame_phase = PH_BODY;
					frame_pos = POS_FUNC;
				end else begin
					// unknown function: drop the address, the byte may start a frame
					seek_address(b);
				end
			end
			PH_BODY: begin
				frame_pos = frame_pos + 3'd1;
				if (frame_status) begin
					if (frame_pos == POS_STATUS)
						frame_status_byte = b;
					if (frame_pos == POS_STATUS_LAST) begin
						cnt = frame_b ? presses_b : presses_a;
						if (frame_status_byte != STATUS_PRESSED) begin
							cnt = 4'd0;
						end else begin
							cnt = cnt + 4'd1;
							if (cnt >= presses_shadow) begin
								cnt = 4'd0;
								lamps = lamps | (frame_b ? LAMP_B : LAMP_A) | LAMP_SHARED;
								word.button_id = frame_b;
								word.button_address = frame_b ? addr_b_shadow : addr_a_shadow;
								word.light_flags = lamps;
								clicks_due.push_back(word);
							end
						end
						if (frame_b)
							presses_b = cnt;
						else
							presses_a = cnt;
						frame_phase = PH_HUNT;
						frame_pos = POS_START;
					end
				end else if (frame_pos == POS_ECHO_LAST) begin
					// write echo is skipped whole
					frame_phase = PH_HUNT;
					frame_pos = POS_START;
				end
			end
			default: begin
				seek_address(b);
			end
		endcase
	endfunction

	// result side: check each click word, track accepted bytes, stall at random
	always @(posedge clk) begin
		click_t want;
		if (arst_n && out_valid && out_ready) begin
			if (clicks_due.size() == 0) begin
				$display("%0t unexpected click word: expected none, actual id %0d addr %02h lamps %04b",
					$time, button_id, button_address, light_flags);
				mismatches++;
			end else begin
				want = clicks_due.pop_front();
				if (button_id !== want.button_id) begin
					$display("%0t button_id expected %0d actual %0d",
						$time, want.button_id, button_id);
					mismatches++;
				end
				if (button_address !== want.button_address) begin
					$display("%0t button_address expected %02h actual %02h",
						$time, want.button_address, button_address);
					mismatches++;
				end
				if (light_flags !== want.light_flags) begin
					$display("%0t light_flags expected %04b actual %04b",
						$time, want.light_flags, light_flags);
					mismatches++;
				end
			end
		end
		// prediction runs after the check, so a word never meets its own expectation early
		if (arst_n && in_valid && in_ready)
			parse_byte(rx_byte);
		out_ready <= !(gaps_on && $urandom_range(99) < 9);
	end

	// watchdog: a long run of cycles in which no word moves means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one byte, with a random gap first, and return once it is taken
	task automatic send_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_bytes(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	// let every owed click arrive and the parser take the last byte
	task automatic quiesce();
		in_valid <= 1'b0;
		while (clicks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers while the block is idle
	task automatic load_regs(input logic [7:0] a, input logic [7:0] b, input logic [3:0] need);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= REG_ADDR_A;
		cfg_data <= a;
		@(posedge clk);
		addr_a_shadow = a;
		cfg_index <= REG_ADDR_B;
		cfg_data <= b;
		@(posedge clk);
		addr_b_shadow = b;
		cfg_index <= REG_PRESSES;
		// upper nibble is junk, the register keeps only four bits
		cfg_data <= {4'($urandom_range(15)), need};
		@(posedge clk);
		presses_shadow = need;
		cfg_we <= 1'b0;
	endtask

	// extreme addresses, both function codes, unknown function bytes, address bytes as frame data
	task automatic test_frame_types();
		load_regs(8'h00, 8'hFF, 4'd1);
		// button B status frame, pressed, body carries both address values
		send_bytes('{8'hFF, FUNC_STATUS, 8'h00, STATUS_PRESSED, 8'hFF, 8'h00, 8'h07});
		// write echo from A, skipped
		send_bytes('{8'h00, FUNC_ECHO, 8'h00, 8'hFF, 8'h03, 8'h00, 8'h03, 8'h00});
		// unknown function byte that is not an address
		send_bytes('{8'h00, 8'h55});
		// unknown function byte that is B's address, then a released status
		send_bytes('{8'h00, 8'hFF, FUNC_STATUS, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00});
	endtask

	// shared address goes to A, zero presses needed, registers changed mid frame
	task automatic test_shared_address();
		load_regs(8'h42, 8'h42, 4'd0);
		send_bytes('{8'h42, FUNC_STATUS, 8'h11, STATUS_PRESSED, 8'h22, 8'h33, 8'h44});
		send_bytes('{8'h42, FUNC_STATUS, 8'h01});
		// frame stays with A; the click reports the new A address
		load_regs(8'h99, 8'h42, 4'd0);
		send_bytes('{8'h03, 8'h00, 8'h00, 8'h00});
	endtask

	// one frame-shaped burst: mostly good frames, some echoes, noise and broken frames
	task automatic send_random_frame(input int press_pct);
		int unsigned kind;
		int unsigned n;
		logic [7:0] who;
		kind = $urandom_range(99);
		who = $urandom_range(1) ? addr_b_shadow : addr_a_shadow;
		if (kind < 65) begin
			send_byte(who);
			send_byte(FUNC_STATUS);
			send_byte(8'($urandom));
			send_byte(($urandom_range(99) < press_pct) ? STATUS_PRESSED : 8'($urandom));
			repeat (3) send_byte(8'($urandom));
		end else if (kind < 78) begin
			send_byte(who);
			send_byte(FUNC_ECHO);
			repeat (6) send_byte(8'($urandom));
		end else if (kind < 90) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom));
		end else if (kind < 95) begin
			// address followed by a random function byte
			send_byte(who);
			send_byte(8'($urandom));
		end else begin
			// truncated status frame, the next burst gets eaten as its body
			n = $urandom_range(1, 4);
			send_byte(who);
			send_byte(FUNC_STATUS);
			repeat (n) send_byte(8'($urandom));
		end
	endtask

	task automatic test_random_traffic(input logic [7:0] a, input logic [7:0] b,
			input logic [3:0] need, input int press_pct, input bit gaps, input int n_items);
		int start_items;
		load_regs(a, b, need);
		gaps_on = gaps;
		start_items = accepted_bytes;
		while (accepted_bytes - start_items < n_items)
			send_random_frame(press_pct);
		gaps_on = 1'b1;
	endtask

	initial begin
		logic [7:0] shared;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_types();
		test_shared_address();

		// default addresses, two presses per click
		test_random_traffic(ADDR_A_RST, ADDR_B_RST, PRESSES_RST, 75, 1'b1, 260);
		// extreme addresses, one press per click, no idling on either side
		test_random_traffic(8'h00, 8'hFF, 4'd1, 60, 1'b0, 260);
		// longest press run, mostly pressed statuses so clicks still happen
		test_random_traffic(8'($urandom), 8'($urandom), 4'd15, 97, 1'b1, 260);
		shared = 8'($urandom);
		test_random_traffic(shared, shared, 4'd3, 80, 1'b1, 260);
		test_random_traffic(8'($urandom), 8'($urandom), 4'd0, 50, 1'b1, 260);

		// drain and give the block time to show any stray click word
		quiesce();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
